// File: hw/rtl/sla_pkg.sv
// Shared types and constants for the serial line assembler.
package sla_pkg;

    typedef enum logic [1:0] {
        MODE_BYTE    = 2'd0,
        MODE_TICK    = 2'd1,
        MODE_READ    = 2'd2,
        MODE_RELEASE = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        REG_ECHO_ENABLE     = 2'd0,
        REG_NULL_TERMINATED = 2'd1,
        REG_CHAR_TIMEOUT    = 2'd2,
        REG_READ_TIMEOUT    = 2'd3
    } t_reg_index;

    typedef struct packed {
        t_mode      mode;
        logic [7:0] data_byte;
        logic [2:0] error_flags;
        logic [5:0] read_index;
    } t_in_item;

    typedef struct packed {
        logic       accepted;
        logic       echo_valid;
        logic [7:0] echo_char;
        logic       line_ready;
        logic [6:0] line_length;
        logic [7:0] read_data;
        logic       line_aborted;
        logic       last_result;
    } t_out_item;

    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_BS  = 8'h08;
    localparam logic [7:0] CH_SP  = 8'h20;

    localparam logic [15:0] CHAR_TIMEOUT_RST = 16'd1000;
    localparam logic [15:0] READ_TIMEOUT_RST = 16'd5000;

endpackage

// File: hw/rtl/sla_in_if.sv
// Input request channel of the serial line assembler.
interface sla_in_if import sla_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: hw/rtl/sla_out_if.sv
// Result channel of the serial line assembler.
interface sla_out_if import sla_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: hw/rtl/sla_cfg_if.sv
// Configuration write channel of the serial line assembler.
interface sla_cfg_if import sla_pkg::*; ();
    logic        valid;
    logic        ready;
    t_reg_index  index;
    logic [15:0] wdata;

    modport source (output valid, output index, output wdata, input ready);
    modport sink   (input valid, input index, input wdata, output ready);
endinterface

// File: hw/rtl/sla_line_store.sv
// Line store memory: one write port, one registered read port.
module sla_line_store #(
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [7:0]    i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [7:0]    o_rd_data
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: hw/rtl/serial_line_assembler_unit.sv
// Top level of the serial line assembler: line assembly, echo, hold and read.
//
//  channel  dir  modport  payload
//  i_in     in   sink     t_in_item  (mode, data_byte, error_flags, read_index)
//  o_out    out  source   t_out_item (one result, or one per echoed character)
//  i_cfg    in   sink     index, wdata (always ready)
//
// An accepted request waits in the input register until it can move on, then its results
// load the result register; read data comes from the registered store port.
// One request per cycle for single-result requests while results are taken; an echoing
// request gives one result per echoed character, 1 to 3 of them.
// Reset clears all control state; the store needs no clearing.
// A stalled result still lets one more request enter the input register.
module serial_line_assembler_unit import sla_pkg::*; #(
    parameter int BUFFER_DEPTH = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sla_in_if.sink    i_in,
    sla_out_if.source o_out,
    sla_cfg_if.sink   i_cfg
);

    localparam int AW = $clog2(BUFFER_DEPTH);
    localparam int LW = $clog2(BUFFER_DEPTH + 1);
    localparam int CW = LW + 6;
    localparam logic [LW-1:0] DEPTH_L    = LW'(BUFFER_DEPTH);
    localparam logic [LW-1:0] LAST_POS_L = LW'(BUFFER_DEPTH - 1);
    localparam logic [LW:0]   DEPTH_X    = (LW+1)'(BUFFER_DEPTH);
    localparam logic [LW:0]   LAST_POS_X = (LW+1)'(BUFFER_DEPTH - 1);

    // configuration
    logic        r_echo_en;
    logic        r_null_term;
    logic [15:0] r_char_to;
    logic [15:0] r_read_to;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_echo_en   <= 1'b0;
            r_null_term <= 1'b0;
            r_char_to   <= CHAR_TIMEOUT_RST;
            r_read_to   <= READ_TIMEOUT_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_ECHO_ENABLE:     r_echo_en   <= i_cfg.wdata[0];
                REG_NULL_TERMINATED: r_null_term <= i_cfg.wdata[0];
                REG_CHAR_TIMEOUT:    r_char_to   <= i_cfg.wdata;
                REG_READ_TIMEOUT:    r_read_to   <= i_cfg.wdata;
            endcase
        end
    end

    // line state
    logic          r_receiving, n_receiving;
    logic [LW-1:0] r_write_pos, n_write_pos;
    logic          r_line_held, n_line_held;
    logic [LW-1:0] r_held_len,  n_held_len;
    logic [15:0]   r_gap_timer, n_gap_timer;
    logic [15:0]   r_hold_timer, n_hold_timer;
    // tail bytes of the held line that live outside the store
    logic          r_ovr_last_en, n_ovr_last_en;
    logic [7:0]    r_ovr_last_val, n_ovr_last_val;
    logic          r_ovr_prev_en, n_ovr_prev_en;

    // input and result registers
    logic       r_in_valid;
    t_in_item   r_in;
    logic       r_out_valid;
    t_out_item  r_res;
    logic [1:0] r_echo_n;
    logic [7:0] r_echo [3];
    logic [1:0] r_seq;
    logic       r_use_mem;

    logic w_last;
    logic w_move;
    logic [7:0] w_mem_q;

    assign w_last = (r_echo_n == 2'd0) || (r_seq == r_echo_n - 2'd1);
    assign w_move = r_in_valid && (!r_out_valid || (o_out.ready && w_last));
    assign i_in.ready = !r_in_valid || w_move;

    // step logic
    logic          c_wr_en;
    logic [LW-1:0] c_pos;
    logic [LW:0]   c_pos1;
    logic [LW:0]   c_pos3;
    logic          c_close;
    logic [LW-1:0] c_len;
    logic          c_ovr_last_en;
    logic [7:0]    c_ovr_last_val;
    logic          c_ovr_prev_en;
    logic          c_accepted;
    logic          c_aborted;
    logic [1:0]    c_echo_n;
    logic [7:0]    c_echo [3];
    logic [15:0]   c_timer_dec;
    logic [CW-1:0] c_idx;
    logic [CW-1:0] c_lenx;
    logic          c_hit;
    logic [7:0]    c_rdata;
    logic          c_use_mem;

    always_comb begin
        n_receiving    = r_receiving;
        n_write_pos    = r_write_pos;
        n_line_held    = r_line_held;
        n_held_len     = r_held_len;
        n_gap_timer    = r_gap_timer;
        n_hold_timer   = r_hold_timer;
        n_ovr_last_en  = r_ovr_last_en;
        n_ovr_last_val = r_ovr_last_val;
        n_ovr_prev_en  = r_ovr_prev_en;

        c_pos  = (r_write_pos >= LAST_POS_L) ? LAST_POS_L : r_write_pos;
        c_pos1 = {1'b0, c_pos} + (LW+1)'(1);
        c_pos3 = {1'b0, c_pos} + (LW+1)'(3);

        c_wr_en        = 1'b0;
        c_close        = 1'b0;
        c_len          = c_pos1[LW-1:0];
        c_ovr_last_en  = 1'b0;
        c_ovr_last_val = CH_NUL;
        c_ovr_prev_en  = 1'b0;
        c_accepted     = 1'b1;
        c_aborted      = 1'b0;
        c_echo_n       = 2'd0;
        c_echo[0]      = r_in.data_byte;
        c_echo[1]      = CH_SP;
        c_echo[2]      = CH_BS;
        c_timer_dec    = 16'd0;

        case (r_in.mode)
            MODE_BYTE: begin
                if (r_line_held) begin
                    c_accepted = 1'b0;
                end else if (r_in.error_flags != 3'd0) begin
                    n_receiving = 1'b0;
                    n_write_pos = '0;
                    c_aborted   = 1'b1;
                end else begin
                    c_wr_en     = 1'b1;
                    n_receiving = 1'b1;
                    n_gap_timer = r_char_to;
                    if (r_null_term && r_in.data_byte == CH_NUL) begin
                        c_close = 1'b1;
                        c_len   = c_pos1[LW-1:0];
                    end else if (!r_null_term &&
                                 (r_in.data_byte == CH_CR || r_in.data_byte == CH_LF)) begin
                        c_close = 1'b1;
                        if (c_pos3 <= DEPTH_X) begin
                            c_len          = c_pos3[LW-1:0];
                            c_ovr_prev_en  = 1'b1;
                            c_ovr_last_en  = 1'b1;
                            c_ovr_last_val = CH_NUL;
                        end else begin
                            // CR lands in the last entry, NUL falls off the end
                            c_len          = DEPTH_L;
                            c_ovr_last_en  = 1'b1;
                            c_ovr_last_val = CH_CR;
                        end
                        if (r_echo_en) begin
                            c_echo_n  = 2'd2;
                            c_echo[0] = CH_LF;
                            c_echo[1] = CH_CR;
                        end
                    end else if (r_echo_en && r_in.data_byte == CH_BS) begin
                        c_echo_n    = 2'd3;
                        c_echo[0]   = CH_BS;
                        n_write_pos = (c_pos != '0) ? c_pos - LW'(1) : '0;
                    end else begin
                        if (r_echo_en) begin
                            c_echo_n = 2'd1;
                        end
                        if (c_pos1 >= LAST_POS_X) begin
                            c_close        = 1'b1;
                            c_len          = DEPTH_L;
                            c_ovr_last_en  = 1'b1;
                            c_ovr_last_val = CH_NUL;
                        end else begin
                            n_write_pos = c_pos1[LW-1:0];
                        end
                    end
                end
            end
            MODE_TICK: begin
                if (r_line_held) begin
                    c_timer_dec  = (r_hold_timer != 16'd0) ? r_hold_timer - 16'd1 : 16'd0;
                    n_hold_timer = c_timer_dec;
                    if (c_timer_dec == 16'd0) begin
                        n_line_held = 1'b0;
                        n_held_len  = '0;
                    end
                end else if (r_receiving) begin
                    c_timer_dec = (r_gap_timer != 16'd0) ? r_gap_timer - 16'd1 : 16'd0;
                    n_gap_timer = c_timer_dec;
                    if (c_timer_dec == 16'd0) begin
                        c_close        = 1'b1;
                        c_len          = r_write_pos + LW'(1);
                        c_ovr_last_en  = 1'b1;
                        c_ovr_last_val = CH_NUL;
                    end
                end
            end
            MODE_READ: begin
            end
            MODE_RELEASE: begin
                if (r_line_held) begin
                    n_line_held  = 1'b0;
                    n_held_len   = '0;
                    n_hold_timer = 16'd0;
                end
            end
            default: begin
            end
        endcase

        if (c_close) begin
            n_line_held    = 1'b1;
            n_held_len     = c_len;
            n_hold_timer   = r_read_to;
            n_receiving    = 1'b0;
            n_write_pos    = '0;
            n_ovr_last_en  = c_ovr_last_en;
            n_ovr_last_val = c_ovr_last_val;
            n_ovr_prev_en  = c_ovr_prev_en;
        end

        c_idx     = CW'(r_in.read_index);
        c_lenx    = CW'(r_held_len);
        c_hit     = (r_in.mode == MODE_READ) && r_line_held && (c_idx < c_lenx) &&
                    (c_idx < CW'(BUFFER_DEPTH));
        c_use_mem = 1'b0;
        c_rdata   = 8'd0;
        if (c_hit) begin
            if (r_ovr_last_en && c_idx == c_lenx - CW'(1)) begin
                c_rdata = r_ovr_last_val;
            end else if (r_ovr_prev_en && c_idx == c_lenx - CW'(2)) begin
                c_rdata = CH_CR;
            end else begin
                c_use_mem = 1'b1;
            end
        end
    end

    sla_line_store #(
        .DEPTH (BUFFER_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_move && c_wr_en),
        .i_wr_addr (c_pos[AW-1:0]),
        .i_wr_data (r_in.data_byte),
        .i_rd_en   (w_move),
        .i_rd_addr (AW'(r_in.read_index)),
        .o_rd_data (w_mem_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_receiving   <= 1'b0;
            r_write_pos   <= '0;
            r_line_held   <= 1'b0;
            r_held_len    <= '0;
            r_gap_timer   <= 16'd0;
            r_hold_timer  <= 16'd0;
            r_ovr_last_en <= 1'b0;
            r_ovr_prev_en <= 1'b0;
        end else if (w_move) begin
            r_receiving   <= n_receiving;
            r_write_pos   <= n_write_pos;
            r_line_held   <= n_line_held;
            r_held_len    <= n_held_len;
            r_gap_timer   <= n_gap_timer;
            r_hold_timer  <= n_hold_timer;
            r_ovr_last_en <= n_ovr_last_en;
            r_ovr_prev_en <= n_ovr_prev_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_move) begin
            r_ovr_last_val <= n_ovr_last_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_in_valid <= 1'b1;
        end else if (w_move) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in <= i_in.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_seq       <= 2'd0;
            r_echo_n    <= 2'd0;
        end else if (w_move) begin
            r_out_valid <= 1'b1;
            r_seq       <= 2'd0;
            r_echo_n    <= c_echo_n;
        end else if (r_out_valid && o_out.ready) begin
            if (w_last) begin
                r_out_valid <= 1'b0;
            end else begin
                r_seq <= r_seq + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_move) begin
            r_res.accepted     <= c_accepted;
            r_res.echo_valid   <= 1'b0;
            r_res.echo_char    <= 8'd0;
            r_res.line_ready   <= n_line_held;
            r_res.line_length  <= n_line_held ? 7'(n_held_len) : 7'd0;
            r_res.read_data    <= c_rdata;
            r_res.line_aborted <= c_aborted;
            r_res.last_result  <= 1'b0;
            r_use_mem          <= c_use_mem;
            r_echo[0]          <= c_echo[0];
            r_echo[1]          <= c_echo[1];
            r_echo[2]          <= c_echo[2];
        end
    end

    always_comb begin
        o_out.valid             = r_out_valid;
        o_out.data              = r_res;
        o_out.data.echo_valid   = (r_echo_n != 2'd0);
        o_out.data.echo_char    = (r_echo_n != 2'd0) ? r_echo[r_seq] : 8'd0;
        o_out.data.read_data    = r_use_mem ? w_mem_q : r_res.read_data;
        o_out.data.last_result  = w_last;
    end

    a_held_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_line_held |-> (r_held_len != '0))
        else $error("held line with zero length");

    a_empty_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_line_held |-> (r_held_len == '0))
        else $error("length kept without a held line");

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_write_pos < LAST_POS_L)
        else $error("write position reached the last entry");

    a_idle_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_receiving |-> (r_write_pos == '0))
        else $error("write position moved while idle");

    a_seq_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_seq != 2'd0) |-> (r_echo_n > r_seq))
        else $error("echo sequence ran past its count");

endmodule

// File: test/tb_serial_line_assembler_unit.sv
// Self-checking testbench for the serial line assembler: random traffic against a line predictor.
module tb_serial_line_assembler_unit;
    import sla_pkg::*;

    localparam int LINE_DEPTH = 64;
    localparam int LIMIT      = 200000;
    localparam int LONG_STALL = 300;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    sla_in_if  req_ch ();
    sla_out_if res_ch ();
    sla_cfg_if cfg_ch ();

    serial_line_assembler_unit #(.BUFFER_DEPTH(LINE_DEPTH)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_ch),
        .o_out   (res_ch),
        .i_cfg   (cfg_ch)
    );

    always #1 i_clk = ~i_clk;

    // register copies
    bit          echo_on    = 1'b0;
    bit          null_mode  = 1'b0;
    int unsigned gap_limit  = CHAR_TIMEOUT_RST;
    int unsigned hold_limit = READ_TIMEOUT_RST;

    // line state
    bit          rx_active  = 1'b0;
    logic [7:0]  line_copy [LINE_DEPTH];
    int unsigned rx_pos     = 0;
    bit          held       = 1'b0;
    int unsigned held_len   = 0;
    int unsigned gap_ticks  = 0;
    int unsigned hold_ticks = 0;

    t_in_item  pending_reqs [$];
    t_out_item line_results_due [$];
    t_out_item want;

    bit req_taken   = 1'b0;
    bit res_taken   = 1'b0;
    bit cfg_taken   = 1'b0;
    bit send_eager  = 1'b0;
    bit sink_eager  = 1'b0;
    bit stall_req   = 1'b0;
    int backpressure_left = 0;
    int send_gap    = 0;
    int sink_gap    = 0;
    int cycles      = 0;
    int mismatches  = 0;
    int n_queued    = 0;
    int n_requests  = 0;
    int n_results   = 0;
    int n_closed    = 0;
    int n_aborted   = 0;
    int n_refused   = 0;

    function automatic void store_put(int unsigned pos, logic [7:0] v);
        if (pos < LINE_DEPTH) line_copy[pos] = v;
    endfunction

    function automatic void close_line(int unsigned len);
        if (len > LINE_DEPTH) len = LINE_DEPTH;
        held_len   = len;
        held       = 1'b1;
        hold_ticks = hold_limit;
        rx_active  = 1'b0;
        rx_pos     = 0;
        n_closed++;
    endfunction

    function automatic void assemble_step(t_in_item it);
        logic [7:0]  echoes [$];
        bit          took;
        bit          aborted;
        logic [7:0]  rdata;
        int unsigned pos;
        int          n;
        t_out_item   r;
        took    = 1'b1;
        aborted = 1'b0;
        rdata   = 8'h00;
        case (it.mode)
            MODE_BYTE: begin
                if (held) begin
                    took = 1'b0;
                    n_refused++;
                end else if (it.error_flags != 3'd0) begin
                    rx_active = 1'b0;
                    rx_pos    = 0;
                    aborted   = 1'b1;
                    n_aborted++;
                end else begin
                    pos = (rx_pos >= LINE_DEPTH - 1) ? LINE_DEPTH - 1 : rx_pos;
                    store_put(pos, it.data_byte);
                    rx_active = 1'b1;
                    gap_ticks = gap_limit;
                    if (null_mode && it.data_byte == CH_NUL) begin
                        close_line(pos + 1);
                    end else if (!null_mode && (it.data_byte == CH_CR ||
                                                it.data_byte == CH_LF)) begin
                        store_put(pos + 1, CH_CR);
                        store_put(pos + 2, CH_NUL);
                        if (echo_on) begin
                            echoes.push_back(CH_LF);
                            echoes.push_back(CH_CR);
                        end
                        close_line(pos + 3);
                    end else if (echo_on && it.data_byte == CH_BS) begin
                        echoes.push_back(CH_BS);
                        echoes.push_back(CH_SP);
                        echoes.push_back(CH_BS);
                        rx_pos = (pos > 0) ? pos - 1 : 0;
                    end else begin
                        if (echo_on) echoes.push_back(it.data_byte);
                        pos++;
                        if (pos >= LINE_DEPTH - 1) begin
                            store_put(LINE_DEPTH - 1, CH_NUL);
                            close_line(LINE_DEPTH);
                        end else begin
                            rx_pos = pos;
                        end
                    end
                end
            end
            MODE_TICK: begin
                if (held) begin
                    if (hold_ticks > 0) hold_ticks--;
                    if (hold_ticks == 0) begin
                        held     = 1'b0;
                        held_len = 0;
                    end
                end else if (rx_active) begin
                    if (gap_ticks > 0) gap_ticks--;
                    if (gap_ticks == 0) begin
                        store_put(rx_pos, CH_NUL);
                        close_line(rx_pos + 1);
                    end
                end
            end
            MODE_READ: begin
                if (held && it.read_index < held_len) rdata = line_copy[it.read_index];
            end
            default: begin
                if (held) begin
                    held       = 1'b0;
                    held_len   = 0;
                    hold_ticks = 0;
                end
            end
        endcase
        n = (echoes.size() > 0) ? echoes.size() : 1;
        for (int k = 0; k < n; k++) begin
            r.accepted     = took;
            r.echo_valid   = (k < echoes.size());
            r.echo_char    = (k < echoes.size()) ? echoes[k] : 8'h00;
            r.line_ready   = held;
            r.line_length  = held ? 7'(held_len) : 7'd0;
            r.read_data    = rdata;
            r.line_aborted = aborted;
            r.last_result  = (k == n - 1);
            line_results_due.push_back(r);
        end
    endfunction

    function automatic string fmt_result(t_out_item r);
        return $sformatf("acc=%0d ev=%0d ech=%02h rdy=%0d len=%0d rd=%02h abt=%0d last=%0d",
                         r.accepted, r.echo_valid, r.echo_char, r.line_ready,
                         r.line_length, r.read_data, r.line_aborted, r.last_result);
    endfunction

    // request and result sampling, prediction, checking
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("no progress after %0d cycles", cycles);
            $display("Regression FAIL");
            $finish;
        end else begin
            req_taken = i_rst_n && req_ch.valid && req_ch.ready;
            res_taken = i_rst_n && res_ch.valid && res_ch.ready;
            cfg_taken = i_rst_n && cfg_ch.valid && cfg_ch.ready;
            if (req_taken) begin
                assemble_step(req_ch.data);
                n_requests++;
            end
            if (res_taken) begin
                n_results++;
                if (line_results_due.size() == 0) begin
                    if (mismatches < 10)
                        $display("unexpected result: %s", fmt_result(res_ch.data));
                    mismatches++;
                end else begin
                    want = line_results_due.pop_front();
                    if (res_ch.data.accepted     !== want.accepted    ||
                        res_ch.data.echo_valid   !== want.echo_valid  ||
                        res_ch.data.echo_char    !== want.echo_char   ||
                        res_ch.data.line_ready   !== want.line_ready  ||
                        res_ch.data.line_length  !== want.line_length ||
                        res_ch.data.read_data    !== want.read_data   ||
                        res_ch.data.line_aborted !== want.line_aborted ||
                        res_ch.data.last_result  !== want.last_result) begin
                        if (mismatches < 10) begin
                            $display("result %0d mismatch", n_results);
                            $display("  expected %s", fmt_result(want));
                            $display("  actual   %s", fmt_result(res_ch.data));
                        end
                        mismatches++;
                    end
                end
            end
        end
    end

    // request driver
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!req_ch.valid || req_taken) begin
                if (send_gap > 0) begin
                    send_gap--;
                    req_ch.valid <= 1'b0;
                end else if (pending_reqs.size() != 0) begin
                    req_ch.data  <= pending_reqs.pop_front();
                    req_ch.valid <= 1'b1;
                    send_gap = send_eager ? 0 : $urandom_range(0, 14);
                end else begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // result sink
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (res_taken) sink_gap = sink_eager ? 0 : $urandom_range(0, 14);
            if (sink_gap > 0) begin
                sink_gap--;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= (backpressure_left == 0);
            end
        end
    end

    // long receiver stall
    always @(negedge i_clk) begin
        if (stall_req) begin
            stall_req         <= 1'b0;
            backpressure_left <= LONG_STALL;
        end else if (backpressure_left != 0) begin
            backpressure_left <= backpressure_left - 1;
        end
    end

    function automatic t_in_item byte_req(logic [7:0] b, logic [2:0] errs);
        t_in_item it;
        it.mode        = MODE_BYTE;
        it.data_byte   = b;
        it.error_flags = errs;
        it.read_index  = 6'($urandom_range(0, 63));
        return it;
    endfunction

    function automatic t_in_item ctrl_req(t_mode m, logic [5:0] idx);
        t_in_item it;
        it.mode        = m;
        it.data_byte   = 8'($urandom_range(0, 255));
        it.error_flags = 3'($urandom_range(0, 7));
        it.read_index  = idx;
        return it;
    endfunction

    function automatic logic [7:0] plain_char();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        while (c == CH_CR || c == CH_LF || c == CH_NUL || c == CH_BS)
            c = 8'($urandom_range(0, 255));
        return c;
    endfunction

    function automatic logic [7:0] line_end();
        if (null_mode) return CH_NUL;
        return $urandom_range(0, 1) ? CH_CR : CH_LF;
    endfunction

    function automatic void offer(t_in_item it);
        pending_reqs.push_back(it);
        n_queued++;
    endfunction

    task automatic write_reg(t_reg_index idx, logic [15:0] val);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.wdata <= val;
        @(negedge i_clk);
        while (!cfg_taken) @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
        case (idx)
            REG_ECHO_ENABLE:     echo_on    = val[0];
            REG_NULL_TERMINATED: null_mode  = val[0];
            REG_CHAR_TIMEOUT:    gap_limit  = val;
            default:             hold_limit = val;
        endcase
    endtask

    task automatic set_mode(bit e, bit nm, logic [15:0] ct, logic [15:0] rt);
        write_reg(REG_ECHO_ENABLE, {15'd0, e});
        write_reg(REG_NULL_TERMINATED, {15'd0, nm});
        write_reg(REG_CHAR_TIMEOUT, ct);
        write_reg(REG_READ_TIMEOUT, rt);
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        @(posedge i_clk);
        while (pending_reqs.size() != 0 || req_ch.valid || line_results_due.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic void read_back_line();
        repeat ($urandom_range(1, 3))
            offer(ctrl_req(MODE_READ, ($urandom_range(0, 3) == 0) ?
                           6'($urandom_range(0, 63)) : 6'($urandom_range(0, 10))));
        if ($urandom_range(0, 3) == 0) offer(byte_req(plain_char(), 3'd0));
        if (hold_limit <= 8 && $urandom_range(0, 1))
            repeat ((hold_limit == 0) ? 1 : hold_limit)
                offer(ctrl_req(MODE_TICK, 6'($urandom_range(0, 63))));
        else
            offer(ctrl_req(MODE_RELEASE, 6'($urandom_range(0, 63))));
    endfunction

    function automatic void add_traffic(int budget, int long_len);
        int start_cnt;
        int len;
        int pick;
        start_cnt = n_queued;
        if (long_len > 0) begin
            repeat (long_len) offer(byte_req(plain_char(), 3'd0));
            offer(byte_req(line_end(), 3'd0));
            read_back_line();
        end
        while (n_queued - start_cnt < budget + long_len) begin
            if ($urandom_range(0, 9) < 7) begin
                len = $urandom_range(0, 8);
                for (int k = 0; k < len; k++) begin
                    pick = $urandom_range(0, 11);
                    if (pick == 0)
                        offer(byte_req(CH_BS, 3'd0));
                    else if (pick == 1 && $urandom_range(0, 3) == 0)
                        offer(byte_req(8'($urandom_range(0, 255)), 3'($urandom_range(1, 7))));
                    else
                        offer(byte_req(plain_char(), 3'd0));
                end
                pick = $urandom_range(0, 7);
                if (pick == 0)
                    offer(byte_req(8'($urandom_range(0, 255)), 3'($urandom_range(1, 7))));
                else if (pick <= 2 && gap_limit <= 8)
                    repeat ((gap_limit == 0) ? 1 : gap_limit)
                        offer(ctrl_req(MODE_TICK, 6'($urandom_range(0, 63))));
                else
                    offer(byte_req(line_end(), 3'd0));
                read_back_line();
            end else begin
                repeat ($urandom_range(1, 4))
                    offer('{mode: t_mode'(2'($urandom_range(0, 3))),
                            data_byte: 8'($urandom_range(0, 255)),
                            error_flags: 3'($urandom_range(0, 7)),
                            read_index: 6'($urandom_range(0, 63))});
            end
        end
    endfunction

    initial begin
        req_ch.valid = 1'b0;
        req_ch.data  = '0;
        res_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = REG_ECHO_ENABLE;
        cfg_ch.wdata = '0;
        for (int k = 0; k < LINE_DEPTH; k++) line_copy[k] = 8'h00;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // idle requests, plain bytes, aborts, CR line, refused byte
        offer(ctrl_req(MODE_READ, 6'd63));
        offer(ctrl_req(MODE_RELEASE, 6'd0));
        offer(ctrl_req(MODE_TICK, 6'd0));
        offer(byte_req(8'hFF, 3'd0));
        offer(byte_req(CH_NUL, 3'd0));
        offer(byte_req(CH_BS, 3'd0));
        offer(byte_req(8'h65, 3'b001));
        offer(byte_req(8'h68, 3'd0));
        offer(byte_req(8'h69, 3'b110));
        offer(byte_req(8'h6F, 3'd0));
        offer(byte_req(CH_CR, 3'd0));
        offer(byte_req(8'h78, 3'd0));
        offer(ctrl_req(MODE_READ, 6'd0));
        offer(ctrl_req(MODE_READ, 6'd3));
        offer(ctrl_req(MODE_READ, 6'd4));
        offer(ctrl_req(MODE_RELEASE, 6'd0));
        wait_drained();

        // echo, backspace at start, zero timeouts, NUL end
        set_mode(1'b1, 1'b1, 16'd0, 16'd0);
        offer(byte_req(CH_BS, 3'd0));
        offer(byte_req(8'h61, 3'd0));
        offer(byte_req(CH_BS, 3'd0));
        offer(byte_req(CH_LF, 3'd0));
        offer(ctrl_req(MODE_TICK, 6'd0));
        offer(ctrl_req(MODE_TICK, 6'd0));
        offer(byte_req(8'h7A, 3'd0));
        offer(byte_req(CH_NUL, 3'd0));
        offer(ctrl_req(MODE_READ, 6'd1));
        offer(ctrl_req(MODE_RELEASE, 6'd0));
        wait_drained();

        set_mode(1'b1, 1'b0, 16'd3, 16'd4);
        add_traffic(0, 62);
        wait_drained();

        set_mode(1'b0, 1'b1, 16'd1, 16'd2);
        sink_eager = 1'b1;
        add_traffic(4, 0);
        wait_drained();
        sink_eager = 1'b0;

        set_mode(1'b1, 1'b1, 16'hFFFF, 16'hFFFF);
        add_traffic(0, 63);
        wait_drained();

        set_mode(1'b0, 1'b0, 16'd2, 16'd1);
        add_traffic(4, 0);
        wait_drained();

        set_mode(1'b1, 1'b0, 16'd5, 16'd6);
        send_eager = 1'b1;
        stall_req  = 1'b1;
        add_traffic(4, 0);
        wait_drained();
        send_eager = 1'b0;

        repeat (20) @(posedge i_clk);
        $display("Ran %0d requests giving %0d results over six register settings,",
                 n_requests, n_results);
        $display("with %0d lines closed, %0d aborted and %0d bytes refused.",
                 n_closed, n_aborted, n_refused);
        if (mismatches == 0 && line_results_due.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatches,
                     line_results_due.size());
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
